// ----- design/hsa_pkg.sv -----
// Shared types and constants for the hexagonal snowflake automaton step unit.
// Used by the datapath, the controller, the top level and the testbench; depends on nothing.
package hsa_pkg;

  localparam int GRID_MAX   = 64;
  localparam int LEVEL_BITS = 24;
  localparam int COORD_W    = $clog2(GRID_MAX);
  localparam int SIDE_W     = COORD_W + 1;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int CELLS      = GRID_MAX * GRID_MAX;
  localparam int COUNT_W    = 17;
  localparam int FRAC_BITS  = 16;
  localparam int ALPHA_W    = 18;
  localparam int WC_W       = 20;
  localparam int SUM_W      = LEVEL_BITS + 3;
  localparam int PA_W       = LEVEL_BITS + WC_W;
  localparam int PB_W       = SUM_W + ALPHA_W;
  localparam int NUM_W      = PB_W + 1;
  localparam int DIV_SHIFT  = FRAC_BITS + 2;
  localparam int Q_W        = NUM_W - DIV_SHIFT;
  localparam int RECIP_W    = 30;
  localparam int RECIP_SH   = 31;
  localparam int AV_W       = LEVEL_BITS + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = LEVEL_BITS'(1 << FRAC_BITS);
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
  localparam logic [ALPHA_W-1:0]    ALPHA_MAX = ALPHA_W'(2 << FRAC_BITS);
  // twelve times one, the diffusion divisor
  localparam logic [WC_W-1:0]       DIFF_DIV  = WC_W'(12 << FRAC_BITS);
  localparam logic [NUM_W-1:0]      DIV_HALF  = NUM_W'(6 << FRAC_BITS);
  // ceil(2^31 / 3), exact quotient by three for the quotient range in use
  localparam logic [RECIP_W-1:0]    RECIP3    = RECIP_W'(((64'd1 << RECIP_SH) + 1) / 3);
  localparam logic [COUNT_W-1:0]    COUNT_MAX = '1;

  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 3'd4;

  // update phases of one cell
  localparam logic [3:0] PH_RD_LAST = 4'd6;
  localparam logic [3:0] PH_SELF    = 4'd1;
  localparam logic [3:0] PH_ACC_END = 4'd7;
  localparam logic [3:0] PH_MUL     = 4'd8;
  localparam logic [3:0] PH_RND     = 4'd9;
  localparam logic [3:0] PH_RCP     = 4'd10;
  localparam logic [3:0] PH_WR      = 4'd11;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_HALT, S_HWAIT, S_MARK, S_MWAIT, S_MSET, S_UPD, S_READ, S_RWAIT
  } hsa_state_t;

  typedef struct packed {
    logic [6:0]  grid_size;
    logic [15:0] max_steps;
    logic [17:0] diffusion_rate;
    logic [15:0] background_level;
    logic [15:0] vapour_addition;
  } hsa_cfg_t;

  typedef struct packed {
    logic       latch;
    logic       adv;
    logic       init_wr;
    logic       cnt_clr;
    logic       rd;
    logic [2:0] k;
    logic       addr_req;
    logic       scan;
    logic       mark_set;
    logic       acc_clr;
    logic       acc_self;
    logic       acc_nbr;
    logic       mul;
    logic       rnd;
    logic       rcp;
    logic       upd_wr;
    logic       swap;
    logic       cnt_inc;
    logic       resp;
    logic       resp_read;
    logic       resp_step;
  } hsa_cmd_t;

  typedef struct packed {
    logic last;
    logic halt;
    logic frozen;
    logic in_grid;
  } hsa_stat_t;

endpackage

// ----- design/hsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the level banks and the receptive marks.
module hsa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, registered read port that holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/hsa_dp.sv -----
// Datapath: cell counters, level banks, receptive marks, diffusion arithmetic.
// Depends on hsa_pkg and hsa_ram; driven by hsa_ctrl commands.
module hsa_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  hsa_pkg::hsa_cfg_t            cfg,
  input  hsa_pkg::hsa_cmd_t            cmd,
  input  logic [hsa_pkg::COORD_W-1:0]  row,
  input  logic [hsa_pkg::COORD_W-1:0]  col,
  output hsa_pkg::hsa_stat_t           stat,
  output logic                         done,
  output logic [hsa_pkg::LEVEL_BITS-1:0] cell_value,
  output logic                         stepped,
  output logic [hsa_pkg::COUNT_W-1:0]  step_count
);

  localparam int CW = hsa_pkg::COORD_W;
  localparam int LW = hsa_pkg::LEVEL_BITS;

  logic [hsa_pkg::SIDE_W-1:0] n;
  logic [CW-1:0] nm1, mid, r, c, row_l, col_l, up, dn, lf, rt, side_c, nr_r, nr_c;
  logic [CW-1:0] hr, hc;
  logic hv, halt_hit, bank;
  logic [hsa_pkg::COUNT_W-1:0] count;
  logic [hsa_pkg::ADDR_W-1:0] rd_addr, nbr_addr, cell_addr;
  logic [LW-1:0] qa, qb, cur_rd, init_val, upd_val, self_lvl, nr_self;
  logic qm, self_mark;
  logic [hsa_pkg::SUM_W-1:0] sum6;
  logic [hsa_pkg::ALPHA_W-1:0] alpha;
  logic [hsa_pkg::WC_W-1:0] wc;
  logic [hsa_pkg::PA_W-1:0] prod_a;
  logic [hsa_pkg::PB_W-1:0] prod_b;
  logic [hsa_pkg::NUM_W-1:0] num;
  logic [hsa_pkg::Q_W-1:0] quo;
  logic [hsa_pkg::Q_W+hsa_pkg::RECIP_W-1:0] rprod;
  logic [hsa_pkg::AV_W-1:0] av;
  logic [LW:0] rec_sum;
  logic [LW-1:0] rec;
  logic [LW+1:0] tot;
  logic border;

  // clamp the side length and derive wrap points
  always_comb begin
    if (cfg.grid_size < 7'd3) begin
      n = 7'd3;
    end else if (cfg.grid_size > 7'(hsa_pkg::GRID_MAX)) begin
      n = 7'(hsa_pkg::GRID_MAX);
    end else begin
      n = cfg.grid_size;
    end
    nm1 = CW'(n - 7'd1);
    mid = nm1 >> 1;
  end

  // the current cell (k zero) or one of its hex neighbors, selected by k
  always_comb begin
    up     = (r == '0) ? nm1 : r - 1'b1;
    dn     = (r == nm1) ? '0 : r + 1'b1;
    lf     = (c == '0) ? nm1 : c - 1'b1;
    rt     = (c == nm1) ? '0 : c + 1'b1;
    side_c = r[0] ? rt : lf;
    case (cmd.k)
      3'd0:    begin nr_r = r;  nr_c = c;      end
      3'd1:    begin nr_r = r;  nr_c = lf;     end
      3'd2:    begin nr_r = r;  nr_c = rt;     end
      3'd3:    begin nr_r = up; nr_c = c;      end
      3'd4:    begin nr_r = dn; nr_c = c;      end
      3'd5:    begin nr_r = up; nr_c = side_c; end
      3'd6:    begin nr_r = dn; nr_c = side_c; end
      default: begin nr_r = r;  nr_c = c;      end
    endcase
    nbr_addr  = {nr_r, nr_c};
    cell_addr = {r, c};
    rd_addr   = cmd.addr_req ? {row_l, col_l} : nbr_addr;
  end

  // cell counters, request latch, bank pointer, iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      r <= '0;
      c <= '0;
      bank <= 1'b0;
      count <= '0;
      hv <= 1'b0;
      halt_hit <= 1'b0;
    end else begin
      hv <= cmd.scan;
      if (cmd.latch) begin
        r <= '0;
        c <= '0;
        halt_hit <= 1'b0;
        row_l <= row;
        col_l <= col;
      end else if (cmd.adv) begin
        if (c == nm1) begin
          c <= '0;
          r <= (r == nm1) ? '0 : r + 1'b1;
        end else begin
          c <= c + 1'b1;
        end
      end
      if (hv && border && cur_rd >= hsa_pkg::LEVEL_ONE) begin
        halt_hit <= 1'b1;
      end
      if (cmd.swap) begin
        bank <= ~bank;
      end
      if (cmd.cnt_clr) begin
        count <= '0;
      end else if (cmd.cnt_inc && count != hsa_pkg::COUNT_MAX) begin
        count <= count + 1'b1;
      end
    end
  end

  // remember which cell the border scan read last
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      hr <= r;
      hc <= c;
    end
  end

  assign border = (hr == '0) || (hr == nm1) || (hc == '0) || (hc == nm1);
  assign cur_rd = bank ? qb : qa;

  // status back to the controller
  always_comb begin
    stat.last    = (r == nm1) && (c == nm1);
    stat.halt    = halt_hit || (hv && border && cur_rd >= hsa_pkg::LEVEL_ONE)
                   || (count > {1'b0, cfg.max_steps});
    stat.frozen  = cur_rd >= hsa_pkg::LEVEL_ONE;
    stat.in_grid = ({1'b0, row_l} < n) && ({1'b0, col_l} < n);
  end

  assign init_val = ((r == mid) && (c == mid)) ? hsa_pkg::LEVEL_ONE
                                               : LW'(cfg.background_level);

  hsa_ram #(.WIDTH(LW), .DEPTH(hsa_pkg::CELLS)) u_bank_a (
    .clk(clk), .we((cmd.init_wr && !bank) || (cmd.upd_wr && bank)), .waddr(cell_addr),
    .wdata(cmd.init_wr ? init_val : upd_val), .re(cmd.rd), .raddr(rd_addr), .rdata(qa)
  );

  hsa_ram #(.WIDTH(LW), .DEPTH(hsa_pkg::CELLS)) u_bank_b (
    .clk(clk), .we((cmd.init_wr && bank) || (cmd.upd_wr && !bank)), .waddr(cell_addr),
    .wdata(cmd.init_wr ? init_val : upd_val), .re(cmd.rd), .raddr(rd_addr), .rdata(qb)
  );

  hsa_ram #(.WIDTH(1), .DEPTH(hsa_pkg::CELLS)) u_marks (
    .clk(clk), .we(cmd.scan || cmd.mark_set), .waddr(nbr_addr), .wdata(cmd.mark_set),
    .re(cmd.rd), .raddr(rd_addr), .rdata(qm)
  );

  // diffusion weights from the clamped alpha, vapour addition and the clipped new level
  always_comb begin
    alpha = (cfg.diffusion_rate > hsa_pkg::ALPHA_MAX) ? hsa_pkg::ALPHA_MAX
                                                      : cfg.diffusion_rate;
    wc = hsa_pkg::DIFF_DIV - ((hsa_pkg::WC_W'(alpha) << 2) + (hsa_pkg::WC_W'(alpha) << 1));
    nr_self = self_mark ? '0 : self_lvl;
    num = hsa_pkg::NUM_W'(prod_a) + hsa_pkg::NUM_W'(prod_b) + hsa_pkg::DIV_HALF;
    rec_sum = {1'b0, self_lvl} + (LW+1)'(cfg.vapour_addition);
    if (!self_mark) begin
      rec = '0;
    end else if (rec_sum[LW]) begin
      rec = hsa_pkg::LEVEL_MAX;
    end else begin
      rec = rec_sum[LW-1:0];
    end
    tot = (LW+2)'(rec) + (LW+2)'(av);
    upd_val = (tot > (LW+2)'(hsa_pkg::LEVEL_MAX)) ? hsa_pkg::LEVEL_MAX : tot[LW-1:0];
  end

  // accumulate, multiply, round, divide by three
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      sum6 <= '0;
    end
    if (cmd.acc_self) begin
      self_lvl <= cur_rd;
      self_mark <= qm;
    end
    if (cmd.acc_nbr && !qm) begin
      sum6 <= sum6 + hsa_pkg::SUM_W'(cur_rd);
    end
    if (cmd.mul) begin
      prod_a <= nr_self * wc;
      prod_b <= sum6 * alpha;
    end
    if (cmd.rnd) begin
      quo <= num[hsa_pkg::DIV_SHIFT +: hsa_pkg::Q_W];
    end
    if (cmd.rcp) begin
      rprod <= quo * hsa_pkg::RECIP3;
    end
  end

  assign av = rprod[hsa_pkg::RECIP_SH +: hsa_pkg::AV_W];

  // result strobe and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.resp;
    end
    if (cmd.resp) begin
      cell_value <= cmd.resp_read ? cur_rd : '0;
      stepped <= cmd.resp_step;
    end
  end

  assign step_count = count;

endmodule

// ----- design/hsa_ctrl.sv -----
// Controller state machine: sequences initialize, halt scan, marking,
// cell update and read. Depends on hsa_pkg; drives hsa_dp through hsa_cmd_t.
module hsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         operation,
  input  hsa_pkg::hsa_stat_t stat,
  output hsa_pkg::hsa_cmd_t  cmd,
  output logic               busy
);

  hsa_pkg::hsa_state_t state, state_next;
  logic [3:0] phase, phase_next;

  // hold state and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsa_pkg::S_IDLE;
      phase <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  assign busy = (state != hsa_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd = '0;
    case (state)
      hsa_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          case (operation)
            hsa_pkg::OP_INIT: state_next = hsa_pkg::S_INIT;
            hsa_pkg::OP_STEP: state_next = hsa_pkg::S_HALT;
            hsa_pkg::OP_READ: state_next = hsa_pkg::S_READ;
            default:          cmd.resp = 1'b1;
          endcase
        end
      end
      hsa_pkg::S_INIT: begin
        cmd.init_wr = 1'b1;
        cmd.adv = 1'b1;
        if (stat.last) begin
          cmd.cnt_clr = 1'b1;
          cmd.resp = 1'b1;
          state_next = hsa_pkg::S_IDLE;
        end
      end
      hsa_pkg::S_HALT: begin
        cmd.rd = 1'b1;
        cmd.scan = 1'b1;
        cmd.adv = 1'b1;
        if (stat.last) begin
          state_next = hsa_pkg::S_HWAIT;
        end
      end
      hsa_pkg::S_HWAIT: begin
        if (stat.halt) begin
          cmd.resp = 1'b1;
          state_next = hsa_pkg::S_IDLE;
        end else begin
          state_next = hsa_pkg::S_MARK;
        end
      end
      hsa_pkg::S_MARK: begin
        cmd.rd = 1'b1;
        state_next = hsa_pkg::S_MWAIT;
      end
      hsa_pkg::S_MWAIT: begin
        phase_next = '0;
        if (stat.frozen) begin
          state_next = hsa_pkg::S_MSET;
        end else begin
          cmd.adv = 1'b1;
          state_next = stat.last ? hsa_pkg::S_UPD : hsa_pkg::S_MARK;
        end
      end
      hsa_pkg::S_MSET: begin
        // mark the frozen cell and its six neighbors
        cmd.mark_set = 1'b1;
        cmd.k = phase[2:0];
        phase_next = phase + 1'b1;
        if (phase == hsa_pkg::PH_RD_LAST) begin
          cmd.adv = 1'b1;
          phase_next = '0;
          state_next = stat.last ? hsa_pkg::S_UPD : hsa_pkg::S_MARK;
        end
      end
      hsa_pkg::S_UPD: begin
        phase_next = phase + 1'b1;
        if (phase <= hsa_pkg::PH_RD_LAST) begin
          cmd.rd = 1'b1;
          cmd.k = phase[2:0];
        end
        cmd.acc_clr  = (phase == '0);
        cmd.acc_self = (phase == hsa_pkg::PH_SELF);
        cmd.acc_nbr  = (phase > hsa_pkg::PH_SELF) && (phase <= hsa_pkg::PH_ACC_END);
        cmd.mul      = (phase == hsa_pkg::PH_MUL);
        cmd.rnd      = (phase == hsa_pkg::PH_RND);
        cmd.rcp      = (phase == hsa_pkg::PH_RCP);
        if (phase == hsa_pkg::PH_WR) begin
          cmd.upd_wr = 1'b1;
          cmd.adv = 1'b1;
          phase_next = '0;
          if (stat.last) begin
            cmd.swap = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.resp = 1'b1;
            cmd.resp_step = 1'b1;
            state_next = hsa_pkg::S_IDLE;
          end
        end
      end
      hsa_pkg::S_READ: begin
        cmd.addr_req = 1'b1;
        if (stat.in_grid) begin
          cmd.rd = 1'b1;
          state_next = hsa_pkg::S_RWAIT;
        end else begin
          cmd.resp = 1'b1;
          state_next = hsa_pkg::S_IDLE;
        end
      end
      hsa_pkg::S_RWAIT: begin
        cmd.resp = 1'b1;
        cmd.resp_read = 1'b1;
        state_next = hsa_pkg::S_IDLE;
      end
      default: state_next = hsa_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- design/hex_snowflake_automaton_step_unit.sv -----
// Top level of the hexagonal snowflake automaton step unit.
// Depends on hsa_pkg, hsa_ctrl and hsa_dp; holds the configuration registers.
//
// Usage:
//   A request (operation, row, col) is taken on a clock edge with start high
//   and busy low. Exactly one result follows: done is high for one cycle
//   with cell_value, stepped and step_count valid; the receiver cannot stall.
//   Configuration is written through cfg_valid/cfg_index/cfg_data while the
//   unit is idle; cfg_ready is always high.
// Operations, with n the clamped grid side:
//   initialize  writes all n*n cells, one cell write per cycle.
//   read        one cell read, skipped for a cell outside the grid.
//   iterate     a border scan of all n*n cells, which ends the step when halted;
//               otherwise a marking pass over every cell, then the update of each cell:
//               one read port per bank serves the seven neighbor reads, and the
//               multiply, round and divide stages follow for each cell.
//   Items are handled one at a time; busy stays high until done.
// Reset: synchronous, clears the step count, the bank pointer and the
//   controller; the configuration returns to its default values. Cell
//   memories are not cleared and must be initialized before use.
module hex_snowflake_automaton_step_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        operation,
  input  logic [hsa_pkg::COORD_W-1:0]       row,
  input  logic [hsa_pkg::COORD_W-1:0]       col,
  output logic                              done,
  output logic [hsa_pkg::LEVEL_BITS-1:0]    cell_value,
  output logic                              stepped,
  output logic [hsa_pkg::COUNT_W-1:0]       step_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hsa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  hsa_pkg::hsa_cfg_t  cfg;
  hsa_pkg::hsa_cmd_t  cmd;
  hsa_pkg::hsa_stat_t stat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_size        <= 7'd64;
      cfg.max_steps        <= 16'd1000;
      cfg.diffusion_rate   <= 18'd65536;
      cfg.background_level <= 16'd26214;
      cfg.vapour_addition  <= 16'd66;
    end else if (cfg_valid) begin
      case (cfg_index)
        hsa_pkg::CFG_GRID:  cfg.grid_size        <= cfg_data[6:0];
        hsa_pkg::CFG_MAX:   cfg.max_steps        <= cfg_data[15:0];
        hsa_pkg::CFG_ALPHA: cfg.diffusion_rate   <= cfg_data;
        hsa_pkg::CFG_BETA:  cfg.background_level <= cfg_data[15:0];
        hsa_pkg::CFG_GAMMA: cfg.vapour_addition  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  hsa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .operation(operation),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  hsa_dp u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .row(row), .col(col),
    .stat(stat), .done(done), .cell_value(cell_value), .stepped(stepped),
    .step_count(step_count)
  );

endmodule

// ----- tb/hex_snowflake_automaton_step_unit_tb.sv -----
// Testbench for the hexagonal snowflake automaton step unit.
// Holds its own predictor of the grid, drives requests and configuration writes, and
// checks every result. Depends on hsa_pkg and hex_snowflake_automaton_step_unit.
module hex_snowflake_automaton_step_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LW    = hsa_pkg::LEVEL_BITS;
  localparam int CNT_W = hsa_pkg::COUNT_W;
  localparam int IDX_W = hsa_pkg::CFG_IDX_W;
  localparam int DAT_W = hsa_pkg::CFG_DATA_W;
  localparam int GMAX  = hsa_pkg::GRID_MAX;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int IDLE_LIMIT = 500000;

  typedef struct packed {
    logic [LW-1:0]         value;
    logic                  did_step;
    logic [CNT_W-1:0]      count;
  } outcome_t;

  typedef struct packed {
    logic                  fixed;
    outcome_t              res;
  } note_t;

  // one directed row: either a register write or a request
  typedef struct packed {
    logic                  is_cfg;
    logic [IDX_W-1:0]      idx;
    logic [DAT_W-1:0]      data;
    logic [1:0]            op;
    logic [5:0]            r;
    logic [5:0]            c;
    logic                  fixed;
    logic [LW-1:0]         v;
    logic                  s;
    logic [CNT_W-1:0]      k;
  } dir_row_t;

  logic clk, rst, start, busy, done, stepped, cfg_valid, cfg_ready;
  logic [1:0] operation;
  logic [hsa_pkg::COORD_W-1:0] row, col;
  logic [LW-1:0] cell_value;
  logic [CNT_W-1:0] step_count;
  logic [IDX_W-1:0] cfg_index;
  logic [DAT_W-1:0] cfg_data;

  hex_snowflake_automaton_step_unit u_dut (.*);

  // mirrored configuration and grid state
  logic [6:0]  m_grid = 7'd64;
  logic [15:0] m_max = 16'd1000;
  logic [17:0] m_alpha = 18'd65536;
  logic [15:0] m_beta = 16'd26214;
  logic [15:0] m_gamma = 16'd66;
  logic [LW-1:0] lvl [GMAX][GMAX];
  logic [LW-1:0] nxt [GMAX][GMAX];
  bit recv [GMAX][GMAX];
  logic [CNT_W-1:0] iter_cnt = '0;

  outcome_t expected_results[$];
  note_t    request_notes[$];
  int errors = 0;
  int idle_cycles = 0;
  int init_side = 0;

  function automatic int grid_side();
    if (m_grid < 3) return 3;
    if (m_grid > GMAX) return GMAX;
    return int'(m_grid);
  endfunction

  function automatic longint unsigned open_level(int r, int c);
    return recv[r][c] ? 0 : longint'(lvl[r][c]);
  endfunction

  function automatic longint unsigned clip_add(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > longint'(hsa_pkg::LEVEL_MAX)) ? longint'(hsa_pkg::LEVEL_MAX) : s;
  endfunction

  // advance the automaton by one step; return 0 when halted
  function automatic bit grow_crystal();
    int n, up, dn, lf, rt, sc;
    longint unsigned alpha, div, wc, sum6, num, av, base;
    n = grid_side();
    alpha = (m_alpha > hsa_pkg::ALPHA_MAX) ? longint'(hsa_pkg::ALPHA_MAX)
                                           : longint'(m_alpha);
    div = 12 * 65536;
    wc = div - 6 * alpha;
    if (iter_cnt > m_max) return 0;
    for (int i = 0; i < n; i++)
      if (lvl[i][0] >= hsa_pkg::LEVEL_ONE || lvl[i][n-1] >= hsa_pkg::LEVEL_ONE ||
          lvl[0][i] >= hsa_pkg::LEVEL_ONE || lvl[n-1][i] >= hsa_pkg::LEVEL_ONE) return 0;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) recv[r][c] = 0;
    // mark frozen cells and their neighbors
    for (int r = 0; r < n; r++) begin
      up = (r + n - 1) % n;
      dn = (r + 1) % n;
      for (int c = 0; c < n; c++) begin
        lf = (c + n - 1) % n;
        rt = (c + 1) % n;
        sc = r[0] ? rt : lf;
        if (lvl[r][c] >= hsa_pkg::LEVEL_ONE) begin
          recv[r][c] = 1; recv[dn][c] = 1; recv[up][c] = 1;
          recv[r][lf] = 1; recv[r][rt] = 1; recv[dn][sc] = 1; recv[up][sc] = 1;
        end
      end
    end
    // diffuse and add vapour
    for (int r = 0; r < n; r++) begin
      up = (r + n - 1) % n;
      dn = (r + 1) % n;
      for (int c = 0; c < n; c++) begin
        lf = (c + n - 1) % n;
        rt = (c + 1) % n;
        sc = r[0] ? rt : lf;
        sum6 = open_level(r, lf) + open_level(r, rt) + open_level(up, c) +
               open_level(dn, c) + open_level(dn, sc) + open_level(up, sc);
        num = open_level(r, c) * wc + sum6 * alpha;
        av = (num + div / 2) / div;
        base = recv[r][c] ? clip_add(lvl[r][c], m_gamma) : 0;
        nxt[r][c] = LW'(clip_add(base, av));
      end
    end
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) lvl[r][c] = nxt[r][c];
    if (iter_cnt != hsa_pkg::COUNT_MAX) iter_cnt++;
    return 1;
  endfunction

  function automatic outcome_t predict_request(logic [1:0] op, int r, int c);
    outcome_t o;
    int n, mid;
    o = '0;
    n = grid_side();
    case (op)
      hsa_pkg::OP_INIT: begin
        mid = (n - 1) / 2;
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) lvl[i][j] = LW'(m_beta);
        lvl[mid][mid] = hsa_pkg::LEVEL_ONE;
        iter_cnt = '0;
      end
      hsa_pkg::OP_STEP: o.did_step = grow_crystal();
      hsa_pkg::OP_READ: if (r < n && c < n) o.value = lvl[r][c];
      default: ;
    endcase
    o.count = iter_cnt;
    return o;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // predict on acceptance, check on done
  always @(posedge clk) begin
    outcome_t e;
    note_t nt;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: value %h stepped %b count %0d",
                                     cell_value, stepped, step_count);
        end else begin
          e = expected_results.pop_front();
          if (e.value !== cell_value || e.did_step !== stepped || e.count !== step_count) begin
            errors++;
            if (errors <= 10)
              $display("result differs: exp value %h stepped %b count %0d, got %h %b %0d",
                       e.value, e.did_step, e.count, cell_value, stepped, step_count);
          end
        end
      end
      if (start && !busy) begin
        nt = request_notes.pop_front();
        e = predict_request(operation, int'(row), int'(col));
        if (nt.fixed) e = nt.res;
        expected_results.push_back(e);
      end
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("hex_snowflake_automaton_step_unit: mismatch");
      $finish;
    end
  end

  // drain outstanding results before touching registers
  task automatic wait_quiet();
    while (expected_results.size() != 0 || request_notes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      hsa_pkg::CFG_GRID:  m_grid = data[6:0];
      hsa_pkg::CFG_MAX:   m_max = data[15:0];
      hsa_pkg::CFG_ALPHA: m_alpha = data;
      hsa_pkg::CFG_BETA:  m_beta = data[15:0];
      hsa_pkg::CFG_GAMMA: m_gamma = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hand one request over; start stays high when the next one follows at once
  task automatic send_request(logic [1:0] op, logic [5:0] r, logic [5:0] c, note_t nt);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    if (op == hsa_pkg::OP_INIT) init_side = grid_side();
    request_notes.push_back(nt);
    start <= 1'b1;
    operation <= op;
    row <= r;
    col <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic release_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // random request that never touches unwritten cells
  task automatic random_request();
    logic [1:0] op;
    int pick, n;
    logic [5:0] r, c;
    n = grid_side();
    pick = $urandom_range(0, 99);
    op = (pick < 40) ? hsa_pkg::OP_STEP : (pick < 85) ? hsa_pkg::OP_READ :
         (pick < 92) ? hsa_pkg::OP_INIT : OP_NONE;
    if ((op == hsa_pkg::OP_STEP || op == hsa_pkg::OP_READ) &&
        (init_side == 0 || n > init_side)) op = hsa_pkg::OP_INIT;
    if ($urandom_range(0, 2) == 0) begin
      r = 6'($urandom_range(0, 63));
      c = 6'($urandom_range(0, 63));
    end else begin
      r = 6'($urandom_range(0, n - 1));
      c = 6'($urandom_range(0, n - 1));
    end
    send_request(op, r, c, '0);
  endtask

  dir_row_t plan [18];

  initial begin
    logic [6:0] g;
    note_t nt;
    int unsigned v;
    rst = 1; start = 0; operation = hsa_pkg::OP_INIT; row = '0; col = '0;
    cfg_valid = 0; cfg_index = hsa_pkg::CFG_GRID; cfg_data = '0;
    plan = '{
      '{1'b1, hsa_pkg::CFG_GRID,  18'd0,     hsa_pkg::OP_INIT, 6'd0, 6'd0, 1'b0, 24'd0,
        1'b0, 17'd0},
      '{1'b1, hsa_pkg::CFG_GAMMA, 18'hFFFF,  hsa_pkg::OP_INIT, 6'd0, 6'd0, 1'b0, 24'd0,
        1'b0, 17'd0},
      '{1'b0, hsa_pkg::CFG_GRID,  18'd0,     hsa_pkg::OP_INIT, 6'd0, 6'd0, 1'b1, 24'd0,
        1'b0, 17'd0},
      '{1'b0, hsa_pkg::CFG_GRID,  18'd0,     hsa_pkg::OP_READ, 6'd1, 6'd1, 1'b1, 24'h010000,
        1'b0, 17'd0},
      '{1'b0, hsa_pkg::CFG_GRID,  18'd0,     hsa_pkg::OP_READ, 6'd0, 6'd0, 1'b1, 24'd26214,
        1'b0, 17'd0},
      '{1'b0, hsa_pkg::CFG_GRID,  18'd0,     hsa_pkg::OP_READ, 6'd3, 6'd0, 1'b1, 24'd0,
        1'b0, 17'd0},
      '{1'b0, hsa_pkg::CFG_GRID,  18'd0,     OP_NONE,          6'd63, 6'd63, 1'b1, 24'd0,
        1'b0, 17'd0},
      '{1'b0, hsa_pkg::CFG_GRID,  18'd0,     hsa_pkg::OP_STEP, 6'd0, 6'd0, 1'b0, 24'd0,
        1'b0, 17'd0},
      '{1'b0, hsa_pkg::CFG_GRID,  18'd0,     hsa_pkg::OP_READ, 6'd0, 6'd2, 1'b0, 24'd0,
        1'b0, 17'd0},
      '{1'b0, hsa_pkg::CFG_GRID,  18'd0,     hsa_pkg::OP_STEP, 6'd0, 6'd0, 1'b0, 24'd0,
        1'b0, 17'd0},
      '{1'b1, hsa_pkg::CFG_GRID,  18'd5,     hsa_pkg::OP_INIT, 6'd0, 6'd0, 1'b0, 24'd0,
        1'b0, 17'd0},
      '{1'b1, hsa_pkg::CFG_MAX,   18'd0,     hsa_pkg::OP_INIT, 6'd0, 6'd0, 1'b0, 24'd0,
        1'b0, 17'd0},
      '{1'b1, hsa_pkg::CFG_ALPHA, 18'h3FFFF, hsa_pkg::OP_INIT, 6'd0, 6'd0, 1'b0, 24'd0,
        1'b0, 17'd0},
      '{1'b1, hsa_pkg::CFG_BETA,  18'hFFFF,  hsa_pkg::OP_INIT, 6'd0, 6'd0, 1'b0, 24'd0,
        1'b0, 17'd0},
      '{1'b0, hsa_pkg::CFG_GRID,  18'd0,     hsa_pkg::OP_INIT, 6'd0, 6'd0, 1'b1, 24'd0,
        1'b0, 17'd0},
      '{1'b0, hsa_pkg::CFG_GRID,  18'd0,     hsa_pkg::OP_READ, 6'd4, 6'd4, 1'b1, 24'hFFFF,
        1'b0, 17'd0},
      '{1'b0, hsa_pkg::CFG_GRID,  18'd0,     hsa_pkg::OP_STEP, 6'd0, 6'd0, 1'b0, 24'd0,
        1'b0, 17'd0},
      '{1'b0, hsa_pkg::CFG_GRID,  18'd0,     hsa_pkg::OP_STEP, 6'd0, 6'd0, 1'b0, 24'd0,
        1'b0, 17'd0}
    };
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed rows
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        release_start();
        wait_quiet();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        nt.fixed = plan[i].fixed;
        nt.res = '{plan[i].v, plan[i].s, plan[i].k};
        send_request(plan[i].op, plan[i].r, plan[i].c, nt);
      end
    end

    // random phases; phase two uses the full grid with a single step
    for (int ph = 0; ph < 6; ph++) begin
      release_start();
      wait_quiet();
      if (ph == 2) g = $urandom_range(0, 1) ? 7'd64 : 7'd127;
      else if ($urandom_range(0, 3) == 0) g = 7'($urandom_range(0, 2));
      else g = 7'($urandom_range(3, 9));
      write_reg(hsa_pkg::CFG_GRID, DAT_W'(g));
      v = ($urandom_range(0, 3) == 0) ? 32'hFFFF : $urandom_range(0, 12);
      write_reg(hsa_pkg::CFG_MAX, DAT_W'(v));
      v = $urandom_range(0, 18'h3FFFF);
      write_reg(hsa_pkg::CFG_ALPHA, DAT_W'(v));
      v = $urandom_range(0, 16'hFFFF);
      write_reg(hsa_pkg::CFG_BETA, DAT_W'(v));
      v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF) : $urandom_range(0, 2000);
      write_reg(hsa_pkg::CFG_GAMMA, DAT_W'(v));
      if (ph == 2) begin
        nt = '0;
        send_request(hsa_pkg::OP_INIT, 6'd0, 6'd0, nt);
        send_request(hsa_pkg::OP_STEP, 6'd0, 6'd0, nt);
        send_request(hsa_pkg::OP_READ, 6'd63, 6'd63, nt);
        send_request(hsa_pkg::OP_READ, 6'd32, 6'd31, nt);
      end else begin
        for (int k = 0; k < 20; k++) random_request();
      end
    end
    release_start();

    wait_quiet();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("hex_snowflake_automaton_step_unit: match");
    else $display("hex_snowflake_automaton_step_unit: mismatch");
    $finish;
  end
endmodule

// ----- filelist.f -----
design/hsa_pkg.sv
design/hsa_ram.sv
design/hsa_dp.sv
design/hsa_ctrl.sv
design/hex_snowflake_automaton_step_unit.sv
tb/hex_snowflake_automaton_step_unit_tb.sv
